// ===== src/sbs_pkg.sv =====
package sbs_pkg;

  localparam int ChW  = 8;
  localparam int LenW = 16;

  localparam logic [ChW-1:0] ChBackslash = 8'h5C;
  localparam logic [ChW-1:0] ChQuote     = 8'h22;
  localparam logic [ChW-1:0] ChSemicolon = 8'h3B;
  localparam logic [ChW-1:0] ChRoundOpen = 8'h28;
  localparam logic [ChW-1:0] ChSqOpen    = 8'h5B;
  localparam logic [ChW-1:0] ChCurlyOpen = 8'h7B;
  localparam logic [ChW-1:0] ChRoundCls  = 8'h29;
  localparam logic [ChW-1:0] ChSqCls     = 8'h5D;
  localparam logic [ChW-1:0] ChCurlyCls  = 8'h7D;
  localparam logic [ChW-1:0] ChCr        = 8'h0D;
  localparam logic [ChW-1:0] ChLf        = 8'h0A;
  localparam logic [ChW-1:0] ChTab       = 8'h09;
  localparam logic [ChW-1:0] ChSpace     = 8'h20;

  localparam logic OutcomeFound      = 1'b0;
  localparam logic OutcomeIncomplete = 1'b1;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           is_end;
  } item_t;

  typedef struct packed {
    logic            outcome;
    logic [LenW-1:0] length;
  } result_t;

  // result of one scan step toward the output register
  typedef struct packed {
    logic    found;
    result_t data;
  } scan_res_t;

endpackage

// ===== src/sbs_if.sv =====
interface sbs_in_if;
  import sbs_pkg::*;
  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;
  logic           is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface sbs_out_if;
  import sbs_pkg::*;
  logic            valid;
  logic            ready;
  logic            outcome;
  logic [LenW-1:0] length;

  modport source (output valid, output outcome, output length, input ready);
  modport sink (input valid, input outcome, input length, output ready);
endinterface

// ===== src/sexpr_boundary_scanner_unit.sv =====
// Expression boundary scanner.
// in_i carries one text byte per transaction (ch), or an end marker (is_end)
// that closes the current text. out_o carries at most one result per text:
// outcome 0 with the expression length, or outcome 1 (brackets still open)
// with length 0. Bytes after a result are dropped until the end marker.
// Pipeline: input register, scan logic with its state registers, output
// register. Each transaction waits in the input register until the scan stage
// steps on it, and a result is loaded into the output register for out_o.
// Throughput: one byte per cycle while out_o is not stalled with a result
// pending, set by the state update of the scan stage; in_i stays ready while
// the output register is empty or being drained in the same cycle.
// When out_o stalls with a result pending, the scan stage holds and the
// input register fills, then in_i.ready drops until out_o.ready returns.
// Reset: scan state returns to the start of a text (position zero, leading
// blanks skipped, depths zero), and both registers are emptied.
// MAX_TEXT_LEN bounds the position counter; DEPTH_BITS sizes each bracket
// depth counter, both saturating.
module sexpr_boundary_scanner_unit #(
  parameter int unsigned MAX_TEXT_LEN = 65535,
  parameter int          DEPTH_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbs_in_if.sink     in_i,
  sbs_out_if.source  out_o
);
  import sbs_pkg::*;

  logic      item_valid;
  item_t     item;
  logic      out_free;
  logic      step;
  scan_res_t res;

  assign step = item_valid && out_free;

  sbs_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .consume_i (step),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  sbs_scan_core #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_scan_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  sbs_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );
endmodule

// ===== src/sbs_in_stage.sv =====
module sbs_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbs_in_if.sink         in_i,
  input  logic           consume_i,
  output logic           valid_o,
  output sbs_pkg::item_t item_o
);
  import sbs_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign in_i.ready = !valid_q || consume_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{ch: in_i.ch, is_end: in_i.is_end};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== src/sbs_scan_core.sv =====
module sbs_scan_core #(
  parameter int unsigned MAX_TEXT_LEN = 65535,
  parameter int          DEPTH_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sbs_pkg::item_t     item_i,
  output sbs_pkg::scan_res_t res_o
);
  import sbs_pkg::*;

  localparam int PosW = $clog2(64'(MAX_TEXT_LEN) + 64'd1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_TEXT_LEN);
  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  typedef logic signed [DEPTH_BITS-1:0] depth_t;

  function automatic logic closed(input depth_t r, input depth_t s, input depth_t c);
    return (r[DEPTH_BITS-1] || (r == '0)) && (s[DEPTH_BITS-1] || (s == '0)) &&
           (c[DEPTH_BITS-1] || (c == '0));
  endfunction

  function automatic depth_t inc_sat(input depth_t d);
    return (d != DepthMax) ? d + depth_t'(1) : d;
  endfunction

  function automatic depth_t dec_sat(input depth_t d);
    return (d != DepthMin) ? d - depth_t'(1) : d;
  endfunction

  function automatic logic [LenW-1:0] len_sat(input logic [PosW-1:0] p);
    logic [PosW+LenW-1:0] ext;
    ext = {{LenW{1'b0}}, p};
    return (|ext[PosW+LenW-1:LenW]) ? {LenW{1'b1}} : ext[LenW-1:0];
  endfunction

  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic            lead_q, lead_d;
  logic            esc_q, esc_d;
  logic            str_q, str_d;
  logic            cmt_q, cmt_d;
  depth_t          rnd_q, rnd_d, sq_q, sq_d, cur_q, cur_d;
  logic            given_q, given_d;
  logic            closed_now;
  logic            is_blank;
  logic            found;
  logic [PosW-1:0] flen;

  assign pos_inc    = (pos_q != PosMax) ? pos_q + PosW'(1) : pos_q;
  assign closed_now = closed(rnd_q, sq_q, cur_q);
  assign is_blank   = (item_i.ch == ChSpace) || (item_i.ch == ChTab);

  always_comb begin
    pos_d   = pos_q;
    lead_d  = lead_q;
    esc_d   = esc_q;
    str_d   = str_q;
    cmt_d   = cmt_q;
    rnd_d   = rnd_q;
    sq_d    = sq_q;
    cur_d   = cur_q;
    given_d = given_q;
    found   = 1'b0;
    flen    = pos_q;
    res_o   = '0;

    if (step_i) begin
      if (item_i.is_end) begin
        res_o.found        = !given_q;
        res_o.data.outcome = closed_now ? OutcomeFound : OutcomeIncomplete;
        res_o.data.length  = closed_now ? len_sat(pos_q) : '0;
        pos_d   = '0;
        lead_d  = 1'b1;
        esc_d   = 1'b0;
        str_d   = 1'b0;
        cmt_d   = 1'b0;
        rnd_d   = '0;
        sq_d    = '0;
        cur_d   = '0;
        given_d = 1'b0;
      end else if (!given_q) begin
        pos_d = pos_inc;
        if (!(lead_q && is_blank)) begin
          lead_d = 1'b0;
          if (cmt_q) begin
            if (item_i.ch == ChCr || item_i.ch == ChLf) begin
              cmt_d = 1'b0;
            end
          end else if (esc_q) begin
            esc_d = 1'b0;
          end else begin
            case (item_i.ch) inside
              ChBackslash: esc_d = 1'b1;
              ChQuote:     str_d = !str_q;
              ChSemicolon: begin
                if (!str_q) cmt_d = 1'b1;
              end
              ChSpace, ChTab: begin
                if (!str_q && closed_now) found = 1'b1;
              end
              ChRoundOpen, ChSqOpen, ChCurlyOpen: begin
                if (!str_q) begin
                  if (pos_q != '0 && closed_now) begin
                    found = 1'b1;
                  end else if (item_i.ch == ChRoundOpen) begin
                    rnd_d = inc_sat(rnd_q);
                  end else if (item_i.ch == ChSqOpen) begin
                    sq_d = inc_sat(sq_q);
                  end else begin
                    cur_d = inc_sat(cur_q);
                  end
                end
              end
              ChRoundCls, ChSqCls, ChCurlyCls: begin
                if (!str_q) begin
                  if (item_i.ch == ChRoundCls) begin
                    rnd_d = dec_sat(rnd_q);
                  end else if (item_i.ch == ChSqCls) begin
                    sq_d = dec_sat(sq_q);
                  end else begin
                    cur_d = dec_sat(cur_q);
                  end
                  // closing bracket counts itself in the length
                  if (closed(rnd_d, sq_d, cur_d)) begin
                    found = 1'b1;
                    flen  = pos_inc;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        if (found) begin
          given_d            = 1'b1;
          res_o.found        = 1'b1;
          res_o.data.outcome = OutcomeFound;
          res_o.data.length  = len_sat(flen);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      lead_q  <= 1'b1;
      esc_q   <= 1'b0;
      str_q   <= 1'b0;
      cmt_q   <= 1'b0;
      rnd_q   <= '0;
      sq_q    <= '0;
      cur_q   <= '0;
      given_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      lead_q  <= lead_d;
      esc_q   <= esc_d;
      str_q   <= str_d;
      cmt_q   <= cmt_d;
      rnd_q   <= rnd_d;
      sq_q    <= sq_d;
      cur_q   <= cur_d;
      given_q <= given_d;
    end
  end
endmodule

// ===== src/sbs_out_stage.sv =====
module sbs_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbs_pkg::scan_res_t res_i,
  output logic               free_o,
  sbs_out_if.source          out_o
);
  import sbs_pkg::*;

  logic    valid_q;
  result_t data_q;

  // slot is free this cycle if empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.found) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.found) begin
      data_q <= res_i.data;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.outcome = data_q.outcome;
  assign out_o.length  = data_q.length;
endmodule
